/* sv/uattl_pkg.sv */
// Package for the unit/attribute text lexer: state and result types,
// comment-mode, role, completion and fault codes, character constants.
// No dependencies.
package uattl_pkg;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_OPEN  = 8'h7B;
    localparam logic [7:0] CH_CLOSE = 8'h7D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // phase bits
    localparam int PH_CLASS = 0;
    localparam int PH_SEP   = 1;
    localparam int PH_UNIT  = 2;
    localparam int PH_ATTR  = 3;
    localparam int PH_INSTR = 4;
    localparam int PH_ARG   = 5;

    // attribute side and name-seen bits
    localparam int SD_NAME  = 0;
    localparam int SD_VALUE = 1;
    localparam int NE_CLASS = 0;
    localparam int NE_UNIT  = 1;

    typedef enum logic [2:0] {
        CM_NORMAL = 3'd0,
        CM_SLASH  = 3'd1,
        CM_LINE   = 3'd2,
        CM_BLOCK  = 3'd3,
        CM_STAR   = 3'd4,
        CM_HASH   = 3'd5
    } t_cmode;

    typedef enum logic [2:0] {
        ROLE_SKIP  = 3'd0,
        ROLE_CLASS = 3'd1,
        ROLE_UNIT  = 3'd2,
        ROLE_ANAME = 3'd3,
        ROLE_AVAL  = 3'd4,
        ROLE_INSTR = 3'd5,
        ROLE_ARG   = 3'd6
    } t_role;

    typedef enum logic [1:0] {
        END_NONE  = 2'd0,
        END_NAMES = 2'd1,
        END_ATTR  = 2'd2,
        END_INSTR = 2'd3
    } t_ended;

    typedef enum logic [2:0] {
        FLT_NONE       = 3'd0,
        FLT_OPEN       = 3'd1,
        FLT_CLOSE      = 3'd2,
        FLT_SEPARATOR  = 3'd3,
        FLT_UNEXPECTED = 3'd4
    } t_fault;

    typedef struct packed {
        logic       global_scope;
        logic       unit_scope;
        logic [5:0] phase;
        logic [1:0] side;
        logic [1:0] nonempty;
        t_cmode     cmode;
        t_fault     fault;
    } t_state;

    typedef struct packed {
        t_role      role;
        logic [7:0] byte_out;
        t_ended     ended;
        t_fault     fault;
    } t_result;

    localparam t_state STATE_RESET = '{
        global_scope: 1'b0,
        unit_scope:   1'b0,
        phase:        6'd0,
        side:         2'd0,
        nonempty:     2'd0,
        cmode:        CM_NORMAL,
        fault:        FLT_NONE
    };

endpackage

/* sv/uattl_step.sv */
// Lexer step: classifies one character against the current lexer state and
// gives the next state and the result item. Pure combinational logic.
// Depends on uattl_pkg.
module uattl_step (
    input  uattl_pkg::t_state  i_state,
    input  logic [7:0]         i_byte,
    output uattl_pkg::t_state  o_state,
    output uattl_pkg::t_result o_res
);
    import uattl_pkg::*;

    logic   ws;
    logic   plain;
    t_state nx;
    t_role  role;
    t_ended ended;
    t_fault fault;

    assign ws = (i_byte == CH_SPACE) || (i_byte >= CH_TAB && i_byte <= CH_CR);

    always_comb begin
        nx    = i_state;
        role  = ROLE_SKIP;
        ended = END_NONE;
        fault = FLT_NONE;
        plain = 1'b0;

        if (i_state.fault != FLT_NONE) begin
            fault = i_state.fault;
        end else begin
            unique case (i_state.cmode)
                CM_SLASH: begin
                    if (i_byte == CH_SLASH) begin
                        nx.cmode = CM_LINE;
                        // a line comment closes an open attribute
                        if (i_state.phase[PH_ATTR]) begin
                            nx.side = 2'b01;
                            ended   = END_ATTR;
                        end
                    end else if (i_byte == CH_STAR) begin
                        nx.cmode = CM_BLOCK;
                    end else begin
                        nx.cmode = CM_NORMAL;
                    end
                end
                CM_LINE: begin
                    if (i_byte == CH_NL) nx.cmode = CM_NORMAL;
                end
                CM_BLOCK: begin
                    if (i_byte == CH_STAR) nx.cmode = CM_STAR;
                end
                CM_STAR: begin
                    if (i_byte == CH_SLASH) nx.cmode = CM_NORMAL;
                    else if (i_byte != CH_STAR) nx.cmode = CM_BLOCK;
                end
                CM_HASH: begin
                    // the closing newline is handled as text in the same step
                    if (i_byte == CH_NL) begin
                        nx.cmode = CM_NORMAL;
                        plain    = 1'b1;
                    end
                end
                default: begin
                    nx.cmode = CM_NORMAL;
                    plain    = 1'b1;
                end
            endcase

            if (plain) begin
                if (i_byte == CH_SLASH) begin
                    nx.cmode = CM_SLASH;
                end else if (i_byte == CH_HASH) begin
                    nx.cmode = CM_HASH;
                end else if (i_byte == CH_OPEN) begin
                    if (!i_state.global_scope) begin
                        nx.global_scope    = 1'b1;
                        nx.phase[PH_CLASS] = 1'b1;
                    end else if (!i_state.unit_scope) begin
                        nx.unit_scope      = 1'b1;
                        nx.phase[PH_ATTR]  = 1'b1;
                        nx.side[SD_NAME]   = 1'b1;
                    end else begin
                        fault = FLT_OPEN;
                    end
                end else if (i_byte == CH_CLOSE) begin
                    if (i_state.unit_scope) begin
                        nx.unit_scope      = 1'b0;
                        nx.phase[PH_ATTR]  = 1'b0;
                        nx.phase[PH_CLASS] = 1'b1;
                        nx.side[SD_VALUE]  = 1'b0;
                        nx.nonempty        = 2'b00;
                    end else if (i_state.global_scope) begin
                        nx.global_scope = 1'b0;
                    end else begin
                        fault = FLT_CLOSE;
                    end
                end else if (i_state.phase[PH_CLASS]) begin
                    if (ws && !i_state.nonempty[NE_CLASS]) begin
                        // leading blanks
                    end else if (ws || i_byte == CH_COLON) begin
                        nx.phase[PH_CLASS] = 1'b0;
                        if (i_byte == CH_COLON) nx.phase[PH_UNIT] = 1'b1;
                        else                    nx.phase[PH_SEP]  = 1'b1;
                    end else begin
                        nx.nonempty[NE_CLASS] = 1'b1;
                        role = ROLE_CLASS;
                    end
                end else if (i_state.phase[PH_SEP]) begin
                    if (ws) begin
                        // blanks before the colon
                    end else if (i_byte == CH_COLON) begin
                        nx.phase[PH_SEP]  = 1'b0;
                        nx.phase[PH_UNIT] = 1'b1;
                    end else begin
                        fault = FLT_SEPARATOR;
                    end
                end else if (i_state.phase[PH_UNIT]) begin
                    if (ws && !i_state.nonempty[NE_UNIT]) begin
                        // leading blanks
                    end else if (ws) begin
                        nx.phase[PH_UNIT] = 1'b0;
                        ended = END_NAMES;
                    end else begin
                        nx.nonempty[NE_UNIT] = 1'b1;
                        role = ROLE_UNIT;
                    end
                end else if (i_state.phase[PH_ATTR]) begin
                    if (i_state.side[SD_NAME] && i_byte == CH_AT) begin
                        nx.phase[PH_ATTR]  = 1'b0;
                        nx.phase[PH_INSTR] = 1'b1;
                    end else if (i_byte == CH_COLON) begin
                        nx.side = 2'b10;
                    end else if (i_byte == CH_NL && i_state.side[SD_VALUE]) begin
                        nx.side = 2'b01;
                        ended   = END_ATTR;
                    end else if (!ws) begin
                        role = i_state.side[SD_NAME] ? ROLE_ANAME : ROLE_AVAL;
                    end
                end else if (i_state.phase[PH_INSTR]) begin
                    if (ws) begin
                        nx.phase[PH_INSTR] = 1'b0;
                        nx.phase[PH_ARG]   = 1'b1;
                    end else begin
                        role = ROLE_INSTR;
                    end
                end else if (i_state.phase[PH_ARG]) begin
                    if (i_byte == CH_NL) begin
                        nx.phase[PH_ARG]  = 1'b0;
                        nx.phase[PH_ATTR] = 1'b1;
                        nx.side           = 2'b01;
                        ended             = END_INSTR;
                    end else begin
                        role = ROLE_ARG;
                    end
                end else if (!ws) begin
                    fault = FLT_UNEXPECTED;
                end
            end

            if (fault != FLT_NONE) begin
                nx.fault = fault;
                role     = ROLE_SKIP;
                ended    = END_NONE;
            end
        end
    end

    assign o_state        = nx;
    assign o_res.role     = role;
    assign o_res.byte_out = i_byte;
    assign o_res.ended    = ended;
    assign o_res.fault    = fault;

endmodule

/* sv/unit_attribute_text_lexer_top.sv */
// Top level of the unit/attribute text lexer: input register, lexer state,
// result register and stream handshakes. Depends on uattl_pkg, uattl_step.
//
// Channel   Dir  Item                        tdata / tuser
// s_axis    in   one text character          tdata[7:0] text_byte
// m_axis    out  tagged character            tdata[7:0] byte_out, [9:8] ended,
//                                            [12:10] fault, [15:13] zero;
//                                            tuser[2:0] role
//
// One item per cycle sustained while m_axis is ready; an accepted item passes
// through the input register, then the lexer step into the result register.
// The lexer state is updated as an item moves into the result register.
// A stall on m_axis holds the result; one more item waits in the input
// register, after which s_axis_tready drops.
// Reset (i_rst_n low, synchronous) empties both registers and clears state.
module unit_attribute_text_lexer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] byte_out, [9:8] ended, [12:10] fault
    output logic [2:0]  m_axis_tuser    // [2:0] role
);
    import uattl_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_state     r_state;

    t_state     n_state;
    t_result    n_out;
    logic       advance;

    uattl_step u_step (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .o_state (n_state),
        .o_res   (n_out)
    );

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (s_axis_tready) r_in_valid <= s_axis_tvalid;
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) r_in_byte <= s_axis_tdata;
        if (advance) r_out <= n_out;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.fault, r_out.ended, r_out.byte_out};
    assign m_axis_tuser  = r_out.role;

    // once a fault is stored the lexer state is frozen
    a_fault_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.fault != FLT_NONE) |=> $stable(r_state))
        else $error("lexer state changed after a fault");

    // a faulting item carries no role and no completion mark
    a_fault_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.fault != FLT_NONE) |->
            (r_out.role == ROLE_SKIP && r_out.ended == END_NONE))
        else $error("faulting item carries a role or completion");

    // state only moves when an item passes into the result register
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("lexer state changed without an item");

    // back-pressure on the input only while the input register is occupied
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid && !m_axis_tready))
        else $error("input stalled without cause");

endmodule

/* tb/tb_unit_attribute_text_lexer_top.sv */
// Self-checking bench for the unit/attribute text lexer: a bit-true lexer predictor,
// directed and random text with both-side idling, a long sink hold-off and a sticky fault.
// Depends on uattl_pkg and unit_attribute_text_lexer_top.
module tb_unit_attribute_text_lexer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import uattl_pkg::*;

    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_CHARS = 1500;

    typedef enum int {
        PK_NAME,   // name character: no whitespace, separators or comment starts
        PK_TEXT,   // value or argument text, anything but newline, braces and comment starts
        PK_LINE,   // line or hash comment body
        PK_BLOCK,  // block comment body
        PK_LONE,   // character after a lone slash
        PK_SPACE,
        PK_ANY
    } t_pick;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] text_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [7:0] byte_out, [9:8] ended, [12:10] fault
    logic [2:0]  m_axis_tuser;           // [2:0] role

    t_state  lex_st;
    t_result tagged_q[$];
    int      chars_sent = 0;
    int      err_cnt = 0;
    bit      src_idle_on = 1'b1;
    bit      sink_idle_on = 1'b1;
    logic    hold_active = 1'b0;
    int      stall_left = 0;
    event    hold_kick;

    unit_attribute_text_lexer_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function automatic logic is_blank(input logic [7:0] ch);
        return (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
    endfunction

    function automatic logic [1:0] side_only(input int b);
        logic [1:0] s;
        s = '0;
        s[b] = 1'b1;
        return s;
    endfunction

    // One character of ordinary text against the scope and phase flags.
    function automatic t_fault lex_plain(input logic [7:0] ch, output t_role role,
                                         output t_ended ended);
        logic ws;
        ws = is_blank(ch);
        role = ROLE_SKIP;
        ended = END_NONE;
        if (ch == CH_SLASH) begin
            lex_st.cmode = CM_SLASH;
            return FLT_NONE;
        end
        if (ch == CH_HASH) begin
            lex_st.cmode = CM_HASH;
            return FLT_NONE;
        end
        if (ch == CH_OPEN) begin
            if (!lex_st.global_scope) begin
                lex_st.global_scope = 1'b1;
                lex_st.phase[PH_CLASS] = 1'b1;
                return FLT_NONE;
            end
            if (!lex_st.unit_scope) begin
                lex_st.unit_scope = 1'b1;
                lex_st.phase[PH_ATTR] = 1'b1;
                lex_st.side[SD_NAME] = 1'b1;
                return FLT_NONE;
            end
            return FLT_OPEN;
        end
        if (ch == CH_CLOSE) begin
            if (lex_st.unit_scope) begin
                lex_st.unit_scope = 1'b0;
                lex_st.phase[PH_ATTR] = 1'b0;
                lex_st.phase[PH_CLASS] = 1'b1;
                lex_st.side[SD_VALUE] = 1'b0;
                lex_st.nonempty = '0;
                return FLT_NONE;
            end
            if (lex_st.global_scope) begin
                lex_st.global_scope = 1'b0;
                return FLT_NONE;
            end
            return FLT_CLOSE;
        end
        if (lex_st.phase[PH_CLASS]) begin
            if (ws && !lex_st.nonempty[NE_CLASS]) return FLT_NONE;
            if (ws || ch == CH_COLON) begin
                lex_st.phase[PH_CLASS] = 1'b0;
                lex_st.phase[(ch == CH_COLON) ? PH_UNIT : PH_SEP] = 1'b1;
                return FLT_NONE;
            end
            lex_st.nonempty[NE_CLASS] = 1'b1;
            role = ROLE_CLASS;
            return FLT_NONE;
        end
        if (lex_st.phase[PH_SEP]) begin
            if (ws) return FLT_NONE;
            if (ch == CH_COLON) begin
                lex_st.phase[PH_SEP] = 1'b0;
                lex_st.phase[PH_UNIT] = 1'b1;
                return FLT_NONE;
            end
            return FLT_SEPARATOR;
        end
        if (lex_st.phase[PH_UNIT]) begin
            if (ws && !lex_st.nonempty[NE_UNIT]) return FLT_NONE;
            if (ws) begin
                lex_st.phase[PH_UNIT] = 1'b0;
                ended = END_NAMES;
                return FLT_NONE;
            end
            lex_st.nonempty[NE_UNIT] = 1'b1;
            role = ROLE_UNIT;
            return FLT_NONE;
        end
        if (lex_st.phase[PH_ATTR]) begin
            if (lex_st.side[SD_NAME] && ch == CH_AT) begin
                lex_st.phase[PH_ATTR] = 1'b0;
                lex_st.phase[PH_INSTR] = 1'b1;
                return FLT_NONE;
            end
            if (ch == CH_COLON) begin
                lex_st.side = side_only(SD_VALUE);
                return FLT_NONE;
            end
            if (ch == CH_NL && lex_st.side[SD_VALUE]) begin
                lex_st.side = side_only(SD_NAME);
                ended = END_ATTR;
                return FLT_NONE;
            end
            if (ws) return FLT_NONE;
            role = lex_st.side[SD_NAME] ? ROLE_ANAME : ROLE_AVAL;
            return FLT_NONE;
        end
        if (lex_st.phase[PH_INSTR]) begin
            if (ws) begin
                lex_st.phase[PH_INSTR] = 1'b0;
                lex_st.phase[PH_ARG] = 1'b1;
                return FLT_NONE;
            end
            role = ROLE_INSTR;
            return FLT_NONE;
        end
        if (lex_st.phase[PH_ARG]) begin
            if (ch == CH_NL) begin
                lex_st.phase[PH_ARG] = 1'b0;
                lex_st.phase[PH_ATTR] = 1'b1;
                lex_st.side = side_only(SD_NAME);
                ended = END_INSTR;
                return FLT_NONE;
            end
            role = ROLE_ARG;
            return FLT_NONE;
        end
        if (ws) return FLT_NONE;
        return FLT_UNEXPECTED;
    endfunction

    // Tags one accepted character and advances the predictor state.
    function automatic t_result lex_char(input logic [7:0] ch);
        t_result r;
        t_role   role;
        t_ended  ended;
        t_fault  f;
        role = ROLE_SKIP;
        ended = END_NONE;
        f = FLT_NONE;
        r.byte_out = ch;
        if (lex_st.fault != FLT_NONE) begin
            r.role = ROLE_SKIP;
            r.ended = END_NONE;
            r.fault = lex_st.fault;
            return r;
        end
        case (lex_st.cmode)
            CM_SLASH: begin
                if (ch == CH_SLASH) begin
                    lex_st.cmode = CM_LINE;
                    // a line comment closes an open attribute
                    if (lex_st.phase[PH_ATTR]) begin
                        lex_st.side = side_only(SD_NAME);
                        ended = END_ATTR;
                    end
                end else if (ch == CH_STAR) begin
                    lex_st.cmode = CM_BLOCK;
                end else begin
                    lex_st.cmode = CM_NORMAL;
                end
            end
            CM_LINE: begin
                if (ch == CH_NL) lex_st.cmode = CM_NORMAL;
            end
            CM_BLOCK: begin
                if (ch == CH_STAR) lex_st.cmode = CM_STAR;
            end
            CM_STAR: begin
                if (ch == CH_SLASH) lex_st.cmode = CM_NORMAL;
                else if (ch != CH_STAR) lex_st.cmode = CM_BLOCK;
            end
            CM_HASH: begin
                // the closing newline counts as ordinary text
                if (ch == CH_NL) begin
                    lex_st.cmode = CM_NORMAL;
                    f = lex_plain(ch, role, ended);
                end
            end
            default: begin
                lex_st.cmode = CM_NORMAL;
                f = lex_plain(ch, role, ended);
            end
        endcase
        if (f != FLT_NONE) begin
            lex_st.fault = f;
            role = ROLE_SKIP;
            ended = END_NONE;
        end
        r.role = role;
        r.ended = ended;
        r.fault = f;
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic is_special(input logic [7:0] c);
        return c == CH_SLASH || c == CH_HASH || c == CH_OPEN || c == CH_CLOSE;
    endfunction

    function automatic logic [7:0] pick_byte(input t_pick kind);
        logic [7:0] c;
        logic       ok;
        if (kind == PK_SPACE) begin
            c = 8'($urandom_range(0, 5));
            return (c == 8'd0) ? CH_SPACE : CH_TAB + c - 8'd1;
        end
        do begin
            c = 8'($urandom_range(0, 255));
            case (kind)
                PK_NAME:  ok = !is_blank(c) && !is_special(c) && c != CH_COLON && c != CH_AT;
                PK_TEXT:  ok = !is_special(c) && c != CH_NL;
                PK_LINE:  ok = c != CH_NL;
                PK_BLOCK: ok = c != CH_SLASH;
                PK_LONE:  ok = c != CH_SLASH && c != CH_STAR;
                default:  ok = 1'b1;
            endcase
        end while (!ok);
        return c;
    endfunction

    task automatic send_char(input logic [7:0] ch);
        int gap;
        gap = src_idle_on ? idle_len() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        do @(posedge i_clk); while (!s_axis_tready);
        tagged_q.push_back(lex_char(ch));
        chars_sent++;
    endtask

    // Sends a space instead of any character that would raise the sticky fault.
    task automatic send_safe(input logic [7:0] ch);
        t_state  saved;
        t_result trial;
        saved = lex_st;
        trial = lex_char(ch);
        lex_st = saved;
        send_char((trial.fault == FLT_NONE) ? ch : CH_SPACE);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    task automatic send_run(input t_pick kind, input int lo, input int hi);
        repeat ($urandom_range(lo, hi)) send_safe(pick_byte(kind));
    endtask

    task automatic send_line();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 8) begin
            send_run(PK_SPACE, 0, 1);
            send_run(PK_NAME, 1, 6);
            send_run(PK_SPACE, 0, 1);
            send_safe(CH_COLON);
            send_run(PK_TEXT, 0, 8);
            send_safe(CH_NL);
        end else if (pick < 10) begin
            // attribute cut short by a line comment, or a bare line comment
            if (pick == 8) begin
                send_run(PK_NAME, 1, 4);
                send_safe(CH_COLON);
                send_run(PK_TEXT, 1, 4);
            end
            send_safe(CH_SLASH);
            send_safe(CH_SLASH);
            send_run(PK_LINE, 0, 6);
            send_safe(CH_NL);
        end else if (pick < 13) begin
            send_safe(CH_AT);
            send_run(PK_NAME, 0, 4);
            send_run(PK_SPACE, 1, 1);
            send_run(PK_TEXT, 0, 8);
            send_safe(CH_NL);
        end else if (pick < 15) begin
            send_safe(CH_SLASH);
            send_safe(CH_STAR);
            send_run(PK_BLOCK, 0, 6);
            repeat ($urandom_range(1, 3)) send_safe(CH_STAR);
            send_safe(CH_SLASH);
        end else if (pick < 17) begin
            send_safe(CH_HASH);
            send_run(PK_LINE, 0, 6);
            send_safe(CH_NL);
        end else if (pick < 19) begin
            send_safe(CH_SLASH);
            send_safe(pick_byte(PK_LONE));
        end else begin
            send_safe(pick_byte(PK_ANY));
        end
    endtask

    task automatic send_document();
        send_run(PK_SPACE, 0, 2);
        send_safe(CH_OPEN);
        repeat ($urandom_range(1, 3)) begin
            send_run(PK_SPACE, 0, 2);
            send_run(PK_NAME, 1, 6);
            case ($urandom_range(0, 2))
                0: send_safe(CH_COLON);
                1: begin
                    send_run(PK_SPACE, 1, 2);
                    send_safe(CH_COLON);
                end
                default: begin
                    send_safe(CH_COLON);
                    send_run(PK_SPACE, 1, 2);
                end
            endcase
            send_run(PK_NAME, 1, 6);
            send_run(PK_SPACE, 1, 2);
            send_safe(CH_OPEN);
            repeat ($urandom_range(0, 6)) send_line();
            send_run(PK_SPACE, 0, 2);
            send_safe(CH_CLOSE);
        end
        send_run(PK_SPACE, 0, 2);
        send_safe(CH_CLOSE);
        send_safe(CH_NL);
    endtask

    // ---------------------------------------------------------------- tests

    // names, separator, attribute values at both byte extremes, instruction
    task automatic test_names_and_attrs();
        send_text("{A :U\n{n:");
        send_char(8'h00);
        send_char(8'hFF);
        send_text("\n@i a\n}}\n");
    endtask

    // line comment ending an attribute, star run, hash newline, lone slash
    task automatic test_comments();
        send_text("{C:V {k:v//x\n/*a**/#h\n/q}}\n");
    endtask

    task automatic test_random_documents();
        while (chars_sent < RANDOM_CHARS) begin
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            send_document();
        end
    endtask

    task automatic test_backpressure();
        int stop_at;
        stop_at = chars_sent + 120;
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        -> hold_kick;
        while (chars_sent < stop_at) send_document();
    endtask

    // The fault is sticky and reset comes only once, so this runs last.
    task automatic test_sticky_fault();
        t_fault want;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        want = t_fault'($urandom_range(FLT_OPEN, FLT_UNEXPECTED));
        case (want)
            FLT_OPEN:      send_text("{a:b {{");
            FLT_CLOSE:     send_text("}");
            FLT_SEPARATOR: send_text("{a x");
            default:       send_text("{a:b }x");
        endcase
        repeat (40) send_char(8'($urandom_range(0, 255)));
    endtask

    // ---------------------------------------------------------------- sink and checks

    initial begin
        forever begin
            @(hold_kick);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_active <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : sink_ready
        int n;
        if (hold_active) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            n = sink_idle_on ? idle_len() : 0;
            m_axis_tready <= (n == 0);
            if (n > 0) stall_left <= n - 1;
        end
    end

    function automatic void note_field(input string field, input logic [7:0] want,
                                       input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d got %0d", $time, field, want, got);
            err_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (tagged_q.size() == 0) begin
                $display("%0t: unexpected item, expected none got tdata %h tuser %h",
                         $time, m_axis_tdata, m_axis_tuser);
                err_cnt++;
            end else begin
                want = tagged_q.pop_front();
                note_field("role", 8'(want.role), 8'(m_axis_tuser));
                note_field("byte", want.byte_out, m_axis_tdata[7:0]);
                note_field("ended", 8'(want.ended), 8'(m_axis_tdata[9:8]));
                note_field("fault", 8'(want.fault), 8'(m_axis_tdata[12:10]));
                note_field("padding", 8'h00, 8'(m_axis_tdata[15:13]));
            end
        end
    end

    initial begin
        #(4_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        lex_st = STATE_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_names_and_attrs();
        test_comments();
        test_random_documents();
        test_backpressure();
        test_sticky_fault();
        s_axis_tvalid <= 1'b0;
        while (tagged_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
